// ===== hdl/xml_entity_codec_defines.svh =====
// assertion macros used by the checker file of the xml entity codec
`ifndef XML_ENTITY_CODEC_DEFINES_SVH
`define XML_ENTITY_CODEC_DEFINES_SVH

// clocked assertion, quiet while reset is held
`define XEC_ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds across reset
`define XEC_ASSERT_ALL(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/xec_pkg.sv =====
// shared types and constants of the xml entity codec
`default_nettype none

package xec_pkg;

  // most bytes one transaction can expand into
  localparam int unsigned JOB_BYTES = 5;
  localparam int unsigned JOB_LEN_W = $clog2(JOB_BYTES + 1);

  // work handed from the classifier to the emitter
  typedef struct packed {
    logic [JOB_BYTES-1:0][7:0] bytes;
    logic [JOB_LEN_W-1:0]      len;
    logic                      last;
  } job_t;

  // queue status seen by both sides
  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

endpackage

`default_nettype wire

// ===== hdl/xec_if.sv =====
// channel interfaces of the xml entity codec
`default_nettype none

interface xec_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;
  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface xec_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       has_byte;
  logic       out_last;
  modport source (output valid, output out_byte, output has_byte, output out_last,
                  input ready);
  modport sink   (input valid, input out_byte, input has_byte, input out_last,
                  output ready);
endinterface

interface xec_cfg_if;
  logic valid;
  logic ready;
  logic direction;
  modport source (output valid, output direction, input ready);
  modport sink   (input valid, input direction, output ready);
endinterface

`default_nettype wire

// ===== hdl/xec_front.sv =====
// classifier: holds direction and entity matcher, turns each accepted byte into at most one job
`default_nettype none

module xec_front (
  input  wire logic            clk,
  input  wire logic            rst_n,
  xec_in_if.sink               in_ch,
  xec_cfg_if.sink              cfg_ch,
  input  wire xec_pkg::q_stat_t q_stat,
  output      logic            push,
  output      xec_pkg::job_t   push_job
);

  typedef enum logic [3:0] {
    MP_IDLE = 4'd0,
    MP_AMP  = 4'd1,
    MP_L    = 4'd2,
    MP_LT   = 4'd3,
    MP_G    = 4'd4,
    MP_GT   = 4'd5,
    MP_A    = 4'd6,
    MP_AM   = 4'd7,
    MP_AMPP = 4'd8
  } mp_state_t;

  localparam logic [7:0] CH_AMP  = 8'h26;
  localparam logic [7:0] CH_LT   = 8'h3C;
  localparam logic [7:0] CH_GT   = 8'h3E;
  localparam logic [7:0] CH_SEMI = 8'h3B;
  localparam logic [7:0] CH_A    = 8'h61;
  localparam logic [7:0] CH_M    = 8'h6D;
  localparam logic [7:0] CH_P    = 8'h70;
  localparam logic [7:0] CH_L    = 8'h6C;
  localparam logic [7:0] CH_G    = 8'h67;
  localparam logic [7:0] CH_T    = 8'h74;

  // letters held after the pending '&'
  function automatic logic [1:0] pend_len(mp_state_t s);
    case (s)
      MP_L, MP_G, MP_A:    pend_len = 2'd1;
      MP_LT, MP_GT, MP_AM: pend_len = 2'd2;
      MP_AMPP:             pend_len = 2'd3;
      default:             pend_len = 2'd0;
    endcase
  endfunction

  function automatic logic [7:0] pend_chr(mp_state_t s, logic [1:0] i);
    logic [7:0] c;
    c = 8'h00;
    case (s)
      MP_L, MP_LT:          c = (i == 2'd0) ? CH_L : CH_T;
      MP_G, MP_GT:          c = (i == 2'd0) ? CH_G : CH_T;
      MP_A, MP_AM, MP_AMPP: c = (i == 2'd0) ? CH_A : ((i == 2'd1) ? CH_M : CH_P);
      default:              c = 8'h00;
    endcase
    return c;
  endfunction

  logic          direction_r;
  mp_state_t     state_r, state_nxt;
  mp_state_t     st_after, cont_nxt;
  logic          cont, has_res;
  logic [7:0]    res_chr;
  logic [1:0]    plen;
  xec_pkg::job_t job;
  logic          in_acc;

  assign in_ch.ready  = !q_stat.full;
  assign cfg_ch.ready = 1'b1;
  assign in_acc       = in_ch.valid && in_ch.ready;

  always_comb begin
    job      = '0;
    cont     = 1'b0;
    cont_nxt = MP_IDLE;
    has_res  = 1'b0;
    res_chr  = 8'h00;
    st_after = MP_IDLE;
    plen     = 2'd0;
    job.last = in_ch.in_last;
    if (!direction_r) begin
      case (in_ch.in_byte)
        CH_AMP: begin
          job.bytes = {CH_SEMI, CH_P, CH_M, CH_A, CH_AMP};
          job.len   = 3'd5;
        end
        CH_LT: begin
          job.bytes = {8'h00, CH_SEMI, CH_T, CH_L, CH_AMP};
          job.len   = 3'd4;
        end
        CH_GT: begin
          job.bytes = {8'h00, CH_SEMI, CH_T, CH_G, CH_AMP};
          job.len   = 3'd4;
        end
        default: begin
          job.bytes[0] = in_ch.in_byte;
          job.len      = 3'd1;
        end
      endcase
    end else begin
      // step the matcher
      case (state_r)
        MP_AMP: begin
          cont     = (in_ch.in_byte == CH_L) || (in_ch.in_byte == CH_G) ||
                     (in_ch.in_byte == CH_A);
          cont_nxt = (in_ch.in_byte == CH_L) ? MP_L :
                     ((in_ch.in_byte == CH_G) ? MP_G : MP_A);
        end
        MP_L: begin
          cont = (in_ch.in_byte == CH_T); cont_nxt = MP_LT;
        end
        MP_LT: begin
          cont = (in_ch.in_byte == CH_SEMI); has_res = 1'b1; res_chr = CH_LT;
        end
        MP_G: begin
          cont = (in_ch.in_byte == CH_T); cont_nxt = MP_GT;
        end
        MP_GT: begin
          cont = (in_ch.in_byte == CH_SEMI); has_res = 1'b1; res_chr = CH_GT;
        end
        MP_A: begin
          cont = (in_ch.in_byte == CH_M); cont_nxt = MP_AM;
        end
        MP_AM: begin
          cont = (in_ch.in_byte == CH_P); cont_nxt = MP_AMPP;
        end
        MP_AMPP: begin
          cont = (in_ch.in_byte == CH_SEMI); has_res = 1'b1; res_chr = CH_AMP;
        end
        default: cont = 1'b0;
      endcase
      if (cont) begin
        st_after = cont_nxt;
        if (has_res) begin
          job.bytes[job.len] = res_chr;
          job.len            = job.len + 3'd1;
        end
      end else begin
        // broken entity: drop the '&', emit its letters
        plen = pend_len(state_r);
        for (int i = 0; i < 3; i++) begin
          if (2'(i) < plen) begin
            job.bytes[job.len] = pend_chr(state_r, 2'(i));
            job.len            = job.len + 3'd1;
          end
        end
        if (in_ch.in_byte == CH_AMP) begin
          st_after = MP_AMP;
        end else begin
          job.bytes[job.len] = in_ch.in_byte;
          job.len            = job.len + 3'd1;
        end
      end
      // end of string flushes whatever is still pending
      if (in_ch.in_last) begin
        plen = pend_len(st_after);
        for (int i = 0; i < 3; i++) begin
          if (2'(i) < plen) begin
            job.bytes[job.len] = pend_chr(st_after, 2'(i));
            job.len            = job.len + 3'd1;
          end
        end
        st_after = MP_IDLE;
      end
    end
    state_nxt = st_after;
  end

  assign push     = in_acc && ((job.len != '0) || in_ch.in_last);
  assign push_job = job;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      direction_r <= 1'b0;
      state_r     <= MP_IDLE;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      direction_r <= cfg_ch.direction;
      state_r     <= MP_IDLE;
    end else if (in_acc) begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/xec_queue.sv =====
// two-entry job queue between classifier and emitter
`default_nettype none

module xec_queue (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire xec_pkg::job_t    push_job,
  input  wire logic             pop,
  output      xec_pkg::job_t    head,
  output      xec_pkg::q_stat_t q_stat
);

  xec_pkg::job_t slot_r [2];
  logic          wr_ptr_r, rd_ptr_r;
  logic [1:0]    cnt_r;

  assign head         = slot_r[rd_ptr_r];
  assign q_stat.empty = (cnt_r == 2'd0);
  assign q_stat.full  = (cnt_r == 2'd2);

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

`default_nettype wire

// ===== hdl/xec_back.sv =====
// emitter: walks the head job into the output register one byte per cycle while the sink accepts
`default_nettype none

module xec_back (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire xec_pkg::job_t    head,
  input  wire xec_pkg::q_stat_t q_stat,
  output      logic             pop,
  xec_out_if.source             out_ch
);

  logic                          out_valid_r;
  logic [7:0]                    out_byte_r;
  logic                          has_byte_r, out_last_r;
  logic [xec_pkg::JOB_LEN_W-1:0] idx_r;
  logic                          load, take, done;

  assign load = !out_valid_r || out_ch.ready;
  assign take = load && !q_stat.empty;
  assign done = (head.len == '0) || (idx_r == head.len - 3'd1);
  assign pop  = take && done;

  assign out_ch.valid    = out_valid_r;
  assign out_ch.out_byte = out_byte_r;
  assign out_ch.has_byte = has_byte_r;
  assign out_ch.out_last = out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      if (load) begin
        out_valid_r <= !q_stat.empty;
      end
      if (take) begin
        idx_r <= done ? '0 : idx_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_byte_r <= (head.len != '0) ? head.bytes[idx_r] : 8'h00;
      has_byte_r <= (head.len != '0);
      out_last_r <= head.last && done;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/xml_entity_codec.sv =====
// top level of the xml entity codec
// Byte-stream XML entity codec. With direction 0 every byte passes through
// except '&', '<' and '>', which expand to "&amp;", "&lt;" and "&gt;". With
// direction 1 the entities "&lt;", "&gt;" and "&amp;" collapse back to one
// character; an '&' that starts no known entity is dropped and the letters
// after it come out as they are. in_last closes a string: its final result
// carries out_last, and a last byte that yields nothing produces one result
// with has_byte 0. While the sink accepts, the output delivers one result
// per cycle; a transaction that yields k results (k up to 5, at least one
// on the last byte) holds the emitter until all k are out, so plain bytes
// stream at one per cycle and the input stalls only when the job queue is
// full. A two-entry job queue sits between classifier and emitter, and the
// result sits in an output register, so a stalled sink does not stop the
// next byte from being taken. Write direction only while the codec is idle;
// a write discards any partially matched entity.
`default_nettype none

module xml_entity_codec (
  input  wire logic clk,
  input  wire logic rst_n,
  xec_in_if.sink    in_ch,
  xec_out_if.source out_ch,
  xec_cfg_if.sink   cfg_ch
);

  // classifier to queue
  logic             push;
  xec_pkg::job_t    push_job;
  // queue to emitter
  xec_pkg::job_t    head;
  xec_pkg::q_stat_t q_stat;
  logic             pop;

  // front: direction register, entity matcher, at most one job per byte
  xec_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .cfg_ch   (cfg_ch),
    .q_stat   (q_stat),
    .push     (push),
    .push_job (push_job)
  );

  // decouples input acceptance from output backpressure
  xec_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .q_stat   (q_stat)
  );

  // back: emits the bytes of each job one by one, popping the job after its last byte
  xec_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (head),
    .q_stat (q_stat),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule

`default_nettype wire

// ===== hdl/xec_checker.sv =====
// port-level checks of the xml entity codec and their bind
`default_nettype none

`include "xml_entity_codec_defines.svh"

module xec_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_byte,
  input wire logic       has_byte,
  input wire logic       out_last
);

  // a stalled result keeps its contents
  `XEC_ASSERT_CLK(a_out_hold, out_valid && !out_ready |=> $stable(out_byte) && $stable(has_byte) && $stable(out_last), "stalled result changed")

  // a stalled result is not withdrawn
  `XEC_ASSERT_CLK(a_out_keep, out_valid && !out_ready |=> out_valid, "stalled result dropped")

  // an end marker is always the final, empty result of a string
  `XEC_ASSERT_CLK(a_marker, out_valid && !has_byte |-> out_last && (out_byte == 8'h00), "bad end marker")

  // nothing is offered right after reset
  `XEC_ASSERT_ALL(a_rst_quiet, !rst_n |=> !out_valid, "result after reset")

endmodule

bind xml_entity_codec xec_checker u_xec_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_byte  (out_ch.out_byte),
  .has_byte  (out_ch.has_byte),
  .out_last  (out_ch.out_last)
);

`default_nettype wire
